>>> rtl/fidsm_pkg.sv
`timescale 1ns / 1ps

package fidsm_pkg;

	// Number of recent ids held in the duplicate window.
	localparam int RING_DEPTH = 8;

	// Field widths.
	localparam int ID_W        = 16;
	localparam int OUT_FIELD_W = 5 + ID_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	// A modulo-65536 difference at or above this value means the id went backward.
	localparam logic [ID_W-1:0] BACKWARD_LIMIT = 16'h8000;

	// Probe that travels down the cell chain, one cell per cycle.
	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
		logic            hit;
	} probe_t;

	// Control sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} fsm_state_t;

endpackage

>>> rtl/fidsm_cell.sv
`timescale 1ns / 1ps

module fidsm_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fidsm_pkg::probe_t           probe_in,
	output fidsm_pkg::probe_t           probe_out,
	input  logic                        shift_en,
	input  logic [fidsm_pkg::ID_W-1:0]  shift_in,
	output logic [fidsm_pkg::ID_W-1:0]  entry
);
	import fidsm_pkg::*;

	logic [ID_W-1:0] entry_q;
	probe_t          probe_q;

	// Stored id: takes its neighbor's entry when a new id is pushed into the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift_en) begin
			entry_q <= shift_in;
		end
	end

	// Compare the passing probe with the stored id and hand it on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q.valid <= probe_in.valid;
			probe_q.id    <= probe_in.id;
			probe_q.hit   <= probe_in.hit | (probe_in.valid && (entry_q == probe_in.id));
		end
	end

	assign probe_out = probe_q;
	assign entry     = entry_q;

endmodule

>>> rtl/frame_id_sequence_monitor_core.sv
`timescale 1ns / 1ps

// Frame id sequence monitor.
// Each request on the slave channel is one frame: s_tuser says whether the
// frame carries an id, s_tdata holds the 16-bit id. Each frame yields exactly
// one request on the master channel with the duplicate indication of this
// frame, the sticky reorder, skip, duplicate and seen flags and the highest
// accepted id, all as they stand after this frame.
// The recent ids live in a chain of cells. A frame with an id sends a probe
// down the chain, one cell per cycle; the hit is captured as the probe leaves
// the last cell, then the result state loads the output register once it is
// free. A keyframe goes from idle straight to the result state.
// One frame is processed at a time; s_tready is high only while idle, so a
// new frame is not taken until the previous result is in the output register.
// The result sits in an output register, so the next frame is accepted while
// the previous result waits. If the receiver stalls and the register is still
// full when the next result is ready, the block holds that result and accepts
// nothing more until the register is taken.
// Reset clears the window to zeros, the flags, the last and highest id and the
// resync mark; the block is ready in the first cycle after reset.
module frame_id_sequence_monitor_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fidsm_pkg::ID_W-1:0]          s_tdata,  // [15:0] frame_id
	input  logic [0:0]                          s_tuser,  // [0] has_id
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] is_duplicate, [1] reorder_flag, [2] skip_flag, [3] dup_flag,
	// [4] seen_flag, [20:5] highest_id, [23:21] zero
	output logic [fidsm_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import fidsm_pkg::*;

	fsm_state_t state_q, state_d;

	logic            has_id_q;
	logic [ID_W-1:0] id_q;
	logic            hit_q;

	logic [ID_W-1:0] last_id_q;
	logic [ID_W-1:0] high_id_q;
	logic            resync_q;
	logic            reorder_q, skip_q, dup_q, seen_q;

	logic            out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic            accept, inject, capture, commit, slot_free;
	logic            push;
	logic [ID_W-1:0] diff;
	logic            is_dup_d, reorder_d, skip_d, dup_d, resync_d;
	logic [ID_W-1:0] last_id_d, high_id_d;

	probe_t          probe_chain [RING_DEPTH+1];
	logic [ID_W-1:0] entry       [RING_DEPTH];

	// Probe enters the first cell on the accepting edge.
	assign accept               = s_tvalid && s_tready;
	assign inject               = accept && s_tuser[0];
	assign probe_chain[0].valid = inject;
	assign probe_chain[0].id    = s_tdata;
	assign probe_chain[0].hit   = 1'b0;

	// Chain of window cells; a new id is pushed in at the first cell.
	for (genvar k = 0; k < RING_DEPTH; k++) begin : g_cell
		logic [ID_W-1:0] shift_src;
		if (k == 0) begin : g_head
			assign shift_src = id_q;
		end else begin : g_body
			assign shift_src = entry[k-1];
		end
		fidsm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.probe_in  (probe_chain[k]),
			.probe_out (probe_chain[k+1]),
			.shift_en  (push),
			.shift_in  (shift_src),
			.entry     (entry[k])
		);
	end

	assign slot_free = !out_valid_q || m_tready;

	// Sequencer: next state and strobes.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		capture  = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = s_tuser[0] ? ST_SCAN : ST_RESULT;
				end
			end
			ST_SCAN: begin
				if (probe_chain[RING_DEPTH].valid) begin
					capture = 1'b1;
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (slot_free) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Frame held while the probe walks the chain.
	always_ff @(posedge clk) begin
		if (accept) begin
			has_id_q <= s_tuser[0];
			id_q     <= s_tdata;
		end
		if (accept) begin
			hit_q <= 1'b0;
		end else if (capture) begin
			hit_q <= probe_chain[RING_DEPTH].hit;
		end
	end

	// Sequence checks and next values of the tracking state.
	always_comb begin
		diff      = id_q - last_id_q;
		is_dup_d  = 1'b0;
		reorder_d = reorder_q;
		skip_d    = skip_q;
		dup_d     = dup_q;
		resync_d  = resync_q;
		last_id_d = last_id_q;
		high_id_d = high_id_q;
		push      = 1'b0;
		if (!has_id_q) begin
			resync_d = 1'b1;
		end else if (hit_q) begin
			dup_d    = 1'b1;
			is_dup_d = 1'b1;
		end else begin
			if (!resync_q) begin
				if (diff >= BACKWARD_LIMIT) begin
					reorder_d = 1'b1;
				end else if (diff > {{(ID_W-1){1'b0}}, 1'b1}) begin
					skip_d = 1'b1;
				end
			end
			resync_d  = 1'b0;
			last_id_d = id_q;
			if (id_q > high_id_q) begin
				high_id_d = id_q;
			end
			push = commit;
		end
	end

	// Tracking state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_id_q <= '0;
			high_id_q <= '0;
			resync_q  <= 1'b0;
			reorder_q <= 1'b0;
			skip_q    <= 1'b0;
			dup_q     <= 1'b0;
			seen_q    <= 1'b0;
		end else if (commit) begin
			last_id_q <= last_id_d;
			high_id_q <= high_id_d;
			resync_q  <= resync_d;
			reorder_q <= reorder_d;
			skip_q    <= skip_d;
			dup_q     <= dup_d;
			seen_q    <= 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, high_id_d, 1'b1,
				dup_d, skip_d, reorder_d, is_dup_d};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
